@@ hdl/key_press_event_detector_macros.svh @@
// assertion macros shared by the key press event detector modules
`ifndef KEY_PRESS_EVENT_DETECTOR_MACROS_SVH
`define KEY_PRESS_EVENT_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define KPED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define KPED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kped_pkg.sv @@
// types and constants of the key press event detector
`timescale 1ns / 1ps

package kped_pkg;

    // fixed widths of the stream fields and of the stability counter
    localparam int FIELD_W = 7;
    localparam int COUNT_W = 9;
    localparam int PERIOD_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd510;

    // register reset values
    localparam logic [COUNT_W-1:0] SHORT_COUNT_RST = 9'd5;
    localparam logic [COUNT_W-1:0] LONG_COUNT_RST = 9'd100;
    localparam logic [COUNT_W-1:0] RELEASE_COUNT_RST = 9'd10;
    localparam logic [COUNT_W-1:0] REPEAT_START_RST = 9'd80;
    localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST = 8'd5;

    // register indexes
    localparam logic [2:0] REG_IDLE_LEVELS = 3'd0;
    localparam logic [2:0] REG_LONG_MODE_MASK = 3'd1;
    localparam logic [2:0] REG_REPEAT_MASK = 3'd2;
    localparam logic [2:0] REG_SHORT_COUNT = 3'd3;
    localparam logic [2:0] REG_LONG_COUNT = 3'd4;
    localparam logic [2:0] REG_RELEASE_COUNT = 3'd5;
    localparam logic [2:0] REG_REPEAT_START = 3'd6;
    localparam logic [2:0] REG_REPEAT_PERIOD = 3'd7;

    // thresholds shared by every key
    typedef struct packed {
        logic [COUNT_W-1:0]  short_count;
        logic [COUNT_W-1:0]  long_count;
        logic [COUNT_W-1:0]  release_count;
        logic [COUNT_W-1:0]  repeat_start;
        logic [PERIOD_W-1:0] repeat_period;
    } cnt_cfg_t;

    // full register set
    typedef struct packed {
        logic [FIELD_W-1:0] idle_levels;
        logic [FIELD_W-1:0] long_mode_mask;
        logic [FIELD_W-1:0] repeat_mask;
        cnt_cfg_t           counts;
    } cfg_t;

endpackage

@@ hdl/kped_cfg_regs.sv @@
// configuration register file of the key press event detector
`timescale 1ns / 1ps

module kped_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [8:0]          wr_data,
    output kped_pkg::cfg_t      cfg
);

    kped_pkg::cfg_t cfg_reg;
    kped_pkg::cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                kped_pkg::REG_IDLE_LEVELS:
                    cfg_next.idle_levels = wr_data[kped_pkg::FIELD_W-1:0];
                kped_pkg::REG_LONG_MODE_MASK:
                    cfg_next.long_mode_mask = wr_data[kped_pkg::FIELD_W-1:0];
                kped_pkg::REG_REPEAT_MASK:
                    cfg_next.repeat_mask = wr_data[kped_pkg::FIELD_W-1:0];
                kped_pkg::REG_SHORT_COUNT:
                    cfg_next.counts.short_count = wr_data;
                kped_pkg::REG_LONG_COUNT:
                    cfg_next.counts.long_count = wr_data;
                kped_pkg::REG_RELEASE_COUNT:
                    cfg_next.counts.release_count = wr_data;
                kped_pkg::REG_REPEAT_START:
                    cfg_next.counts.repeat_start = wr_data;
                kped_pkg::REG_REPEAT_PERIOD:
                    cfg_next.counts.repeat_period = wr_data[kped_pkg::PERIOD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_levels <= '0;
            cfg_reg.long_mode_mask <= '0;
            cfg_reg.repeat_mask <= '0;
            cfg_reg.counts.short_count <= kped_pkg::SHORT_COUNT_RST;
            cfg_reg.counts.long_count <= kped_pkg::LONG_COUNT_RST;
            cfg_reg.counts.release_count <= kped_pkg::RELEASE_COUNT_RST;
            cfg_reg.counts.repeat_start <= kped_pkg::REPEAT_START_RST;
            cfg_reg.counts.repeat_period <= kped_pkg::REPEAT_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/kped_key_cell.sv @@
// per-key debounce counter and short, long and repeat press flags
`timescale 1ns / 1ps
`include "key_press_event_detector_macros.svh"

module kped_key_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  logic                level,
    input  logic                ack_short,
    input  logic                ack_long,
    input  logic                idle_level,
    input  logic                long_mode,
    input  logic                repeat_en,
    input  kped_pkg::cnt_cfg_t  counts,
    output logic                short_next,
    output logic                long_next
);

    logic                          last_level_reg;
    logic [kped_pkg::COUNT_W-1:0]  count_reg;
    logic                          short_reg;
    logic                          long_reg;

    logic [kped_pkg::COUNT_W-1:0]  count_next;
    logic [kped_pkg::COUNT_W-1:0]  count_inc;
    logic [kped_pkg::COUNT_W:0]    repeat_sum;
    logic                          changed;
    logic                          pressed;
    logic                          repeat_hit;

    // counter step and repeat point
    always_comb
    begin
        changed = (level != last_level_reg);
        pressed = (level != idle_level);
        count_inc = (count_reg < kped_pkg::COUNT_MAX) ? count_reg + 9'd1 : count_reg;
        repeat_sum = {1'b0, counts.repeat_start} + {2'b00, counts.repeat_period};
        repeat_hit = !changed && !long_mode && repeat_en && pressed &&
                     (counts.repeat_period != '0) && ({1'b0, count_inc} == repeat_sum);
        if (changed)
            count_next = '0;
        else if (repeat_hit)
            count_next = counts.repeat_start;
        else
            count_next = count_inc;
    end

    // flag update: acknowledge, set on thresholds, clear on release
    always_comb
    begin
        short_next = (short_reg & !ack_short) | repeat_hit;
        long_next = long_reg & !ack_long;
        if (!long_mode && pressed && (count_next == counts.short_count))
            short_next = 1'b1;
        if (long_mode && pressed && (count_next == counts.long_count))
            long_next = 1'b1;
        if (!pressed && (count_next == counts.release_count))
        begin
            short_next = 1'b0;
            long_next = 1'b0;
        end
    end

    // key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            count_reg <= '0;
            short_reg <= 1'b0;
            long_reg <= 1'b0;
        end
        else if (tick)
        begin
            last_level_reg <= level;
            count_reg <= count_next;
            short_reg <= short_next;
            long_reg <= long_next;
        end
    end

    `KPED_ASSERT_NOW(a_count_saturates, clk, rst_n, 1'b1, count_reg <= kped_pkg::COUNT_MAX, "stability counter above saturation")
    `KPED_ASSERT_NEXT(a_change_restarts, clk, rst_n, tick && changed, count_reg == '0, "level change did not restart the counter")
    `KPED_ASSERT_NEXT(a_idle_holds_count, clk, rst_n, !tick, $stable(count_reg), "counter moved without a tick")

endmodule

@@ hdl/key_press_event_detector.sv @@
// top level of the key press event detector
`timescale 1ns / 1ps
`include "key_press_event_detector_macros.svh"

// Key press event detector. Each transfer on the s_ side is one scan tick carrying the
// sampled key levels and the two acknowledge masks; each tick gives exactly one transfer
// on the m_ side with the short and long press flags after that tick. The per-key
// counter and flag update is a single combinational pass from the key state registers
// into the output register, so a new tick is taken every cycle while the output
// register is empty or being drained. Configuration writes are taken on any cycle
// (cfg_ready is always high) and must only be issued while the block is idle.

module key_press_event_detector #(
    parameter int NUM_KEYS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    // tick input: key_levels[6:0], ack_short[13:7], ack_long[20:14], zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // flags output: short_flags[6:0], long_flags[13:7], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int FW = kped_pkg::FIELD_W;

    kped_pkg::cfg_t          cfg;
    logic                    s_fire;
    logic                    out_valid_reg;
    logic [FW-1:0]           short_out_reg;
    logic [FW-1:0]           long_out_reg;
    logic [FW-1:0]           short_out_next;
    logic [FW-1:0]           long_out_next;
    logic [NUM_KEYS-1:0]     short_next;
    logic [NUM_KEYS-1:0]     long_next;

    assign cfg_ready = 1'b1;
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire = s_tvalid && s_tready;

    kped_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // one cell per key; keys past the field width see level 0 and zero masks, with the shared thresholds
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        if (k < FW)
        begin : g_mapped
            kped_key_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .tick       (s_fire),
                .level      (s_tdata[k]),
                .ack_short  (s_tdata[FW + k]),
                .ack_long   (s_tdata[2*FW + k]),
                .idle_level (cfg.idle_levels[k]),
                .long_mode  (cfg.long_mode_mask[k]),
                .repeat_en  (cfg.repeat_mask[k]),
                .counts     (cfg.counts),
                .short_next (short_next[k]),
                .long_next  (long_next[k])
            );
        end
        else
        begin : g_extra
            kped_key_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .tick       (s_fire),
                .level      (1'b0),
                .ack_short  (1'b0),
                .ack_long   (1'b0),
                .idle_level (1'b0),
                .long_mode  (1'b0),
                .repeat_en  (1'b0),
                .counts     (cfg.counts),
                .short_next (short_next[k]),
                .long_next  (long_next[k])
            );
        end
    end

    // map key flags onto the fixed-width output fields
    for (genvar j = 0; j < FW; j++)
    begin : g_out
        if (j < NUM_KEYS)
        begin : g_used
            assign short_out_next[j] = short_next[j];
            assign long_out_next[j] = long_next[j];
        end
        else
        begin : g_unused
            assign short_out_next[j] = 1'b0;
            assign long_out_next[j] = 1'b0;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            short_out_reg <= short_out_next;
            long_out_reg <= long_out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, long_out_reg, short_out_reg};

    `KPED_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid_reg, s_tready, "input stalled with empty output register")
    `KPED_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, out_valid_reg && !m_tready, !s_tready, "input taken while result is stalled")
    `KPED_ASSERT_NEXT(a_tick_gives_result, clk, rst_n, s_fire, out_valid_reg, "accepted tick produced no result")

endmodule
